### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned KeyWidthDef   = 16;

  // Fixed widths of the stream fields.
  localparam int unsigned KeyPortW  = 16;
  localparam int unsigned TotalW    = 5;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 24;

  // Bit positions in the result tdata.
  localparam int unsigned FrontLsb  = 0;
  localparam int unsigned TotalLsb  = FrontLsb + KeyPortW;
  localparam int unsigned EmptyBit  = TotalLsb + TotalW;
  localparam int unsigned ErrorBit  = EmptyBit + 1;

  typedef enum logic {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

### src/spq_cell.sv
// One slot of the sorted chain: holds a key and trades it with its neighbors.
module spq_cell #(
  parameter int unsigned KEY_WIDTH = spq_pkg::KeyWidthDef,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned IDX       = 0
) (
  input  logic                    clk_i,
  input  spq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [KEY_WIDTH-1:0]    new_key_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [KEY_WIDTH-1:0]    prev_key_i,
  input  logic                    prev_after_i,
  input  logic [KEY_WIDTH-1:0]    next_key_i,
  output logic [KEY_WIDTH-1:0]    key_o,
  output logic                    after_o,
  output logic [KEY_WIDTH-1:0]    key_d_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 occupied;

  assign occupied = count_i > CNT_W'(IDX);

  // This slot sits at or after the insert point unless it holds a smaller key.
  assign after_o = !(occupied && (key_q < new_key_i));

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (prev_after_i) begin
        key_d = prev_key_i;
      end else if (after_o) begin
        key_d = new_key_i;
      end
    end else if (ctrl_i.rem) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign key_d_o = key_d;

endmodule

### src/sorted_priority_queue_top.sv
// Top level of the sorted priority queue built as a chain of key cells.
// A min-priority queue of up to QUEUE_DEPTH keys kept in ascending order in a row
// of identical cells. Each input transfer carries a command in s_axis_tuser (insert
// or remove smallest) and a key in s_axis_tdata. Every accepted transfer yields one
// result transfer with the smallest key (0 when empty), the key count, an empty flag
// and an error flag; an insert when full or a remove when empty raises the error
// flag and leaves the queue unchanged. For each item, every cell compares its key
// with the incoming one and picks its next value from itself, its left neighbor or
// the new key (insert), or from its right neighbor (remove), so the whole chain
// updates in the same cycle. The result lands in an output register in the cycle
// after acceptance; a new item is taken while that register is empty or being
// drained, giving one item per cycle under no back-pressure. Equal keys: a new key
// goes ahead of stored keys equal to it. Key storage has no reset; only slots below
// the count are ever shown.
module sorted_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDef,
  parameter int unsigned KEY_WIDTH   = spq_pkg::KeyWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spq_pkg::InDataW-1:0]   s_axis_tdata,   // [15:0] key_value
  input  logic                          s_axis_tuser,   // [0] command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spq_pkg::OutDataW-1:0]  m_axis_tdata    // [15:0] front_key,
                                                        // [20:16] entry_total,
                                                        // [21] is_empty,
                                                        // [22] op_error, [23] zero
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]      count_q, count_d;
  logic                 accept, is_full, is_zero, op_err;
  spq_pkg::cmd_e        cmd;
  spq_pkg::cell_ctrl_t  ctrl;
  logic [KEY_WIDTH-1:0] new_key;

  logic [KEY_WIDTH+spq_pkg::KeyPortW-1:0] key_in_wide;
  logic [KEY_WIDTH+spq_pkg::KeyPortW-1:0] key_out_wide;
  logic [CntW+spq_pkg::TotalW-1:0]        total_wide;

  logic [KEY_WIDTH-1:0] cell_key   [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0] cell_key_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_after;

  logic                         m_valid_q;
  logic [spq_pkg::OutDataW-1:0] m_data_q, m_data_d;
  logic [spq_pkg::KeyPortW-1:0] front_key;
  logic [spq_pkg::TotalW-1:0]   entry_total;

  // Take a new item whenever the result register is free or draining.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = spq_pkg::cmd_e'(s_axis_tuser);

  // Fit the port key to the internal key width (mask or zero-extend).
  assign key_in_wide = {{KEY_WIDTH{1'b0}}, s_axis_tdata[spq_pkg::KeyPortW-1:0]};
  assign new_key     = key_in_wide[KEY_WIDTH-1:0];

  assign is_full = count_q == CntW'(QUEUE_DEPTH);
  assign is_zero = count_q == '0;
  assign op_err  = (cmd == spq_pkg::CmdInsert) ? is_full : is_zero;

  // Broadcast the command to the chain only when it will really change state.
  assign ctrl.ins = accept && (cmd == spq_pkg::CmdInsert) && !is_full;
  assign ctrl.rem = accept && (cmd == spq_pkg::CmdRemove) && !is_zero;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] prev_key, next_key;
    logic                 prev_after;

    if (i == 0) begin : g_head
      assign prev_key   = new_key;
      assign prev_after = 1'b0;
    end else begin : g_mid
      assign prev_key   = cell_key[i-1];
      assign prev_after = cell_after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_body
      assign next_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CntW),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_key_i    (new_key),
      .count_i      (count_q),
      .prev_key_i   (prev_key),
      .prev_after_i (prev_after),
      .next_key_i   (next_key),
      .key_o        (cell_key[i]),
      .after_o      (cell_after[i]),
      .key_d_o      (cell_key_d[i])
    );
  end

  // Build the result from the head cell's next value and the next count.
  assign key_out_wide = {{spq_pkg::KeyPortW{1'b0}}, cell_key_d[0]};
  assign total_wide   = {{spq_pkg::TotalW{1'b0}}, count_d};
  assign front_key    = (count_d != '0) ? key_out_wide[spq_pkg::KeyPortW-1:0] : '0;
  assign entry_total  = total_wide[spq_pkg::TotalW-1:0];

  always_comb begin
    m_data_d = '0;
    m_data_d[spq_pkg::FrontLsb +: spq_pkg::KeyPortW] = front_key;
    m_data_d[spq_pkg::TotalLsb +: spq_pkg::TotalW]   = entry_total;
    m_data_d[spq_pkg::EmptyBit]                      = count_d == '0;
    m_data_d[spq_pkg::ErrorBit]                      = op_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until a new item replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [spq_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [spq_pkg::TotalW-1:0] total;
  logic                       empty;

  assign total = m_axis_tdata[spq_pkg::TotalLsb +: spq_pkg::TotalW];
  assign empty = m_axis_tdata[spq_pkg::EmptyBit];

  // A stalled result keeps its valid and payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input is refused only while an untaken result is pending.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // Every accepted item produces a result on the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // An empty queue reports a zero front key.
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && empty |->
      m_axis_tdata[spq_pkg::FrontLsb +: spq_pkg::KeyPortW] == '0)
    else $error("empty queue with nonzero front key");

  // Empty flag tracks a zero count when the count field is wide enough.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && empty |-> total == '0)
    else $error("empty flag with nonzero count");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
